>>> hw/rtl/rchd_pkg.sv
// shared constants, types and microcode for the ring cache with hit distance
`timescale 1ns / 1ps

package rchd_pkg;

	localparam int RING_DEPTH = 256;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int WORD_W     = 64;
	localparam int KEY_W      = 2 * WORD_W;
	localparam int VAL_W      = 2 * WORD_W;
	localparam int ENT_W      = KEY_W + VAL_W;
	localparam int HIT_W      = 32;
	localparam int DIST_W     = 8;
	localparam int CMD_W      = 2;
	localparam int CI_W       = 8;
	localparam int LIMIT_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);
	localparam logic [HIT_W-1:0]   HIT_MAX     = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP   = 2'd0,
		CMD_INSERT   = 2'd1,
		CMD_READ_CNT = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CACHE_ENABLE = 2'd0,
		REG_ENTRY_LIMIT  = 2'd1
	} reg_idx_t;

	// microcode addresses
	typedef enum logic [3:0] {
		U_FETCH    = 4'd0,
		U_LK_START = 4'd1,
		U_LK_SCAN  = 4'd2,
		U_HIT_RD   = 4'd3,
		U_HIT_WR   = 4'd4,
		U_INS      = 4'd5,
		U_RD       = 4'd6,
		U_RD_DONE  = 4'd7,
		U_EMIT     = 4'd8
	} upc_t;

	typedef enum logic [3:0] {
		ACT_FETCH      = 4'd0,
		ACT_SCAN_START = 4'd1,
		ACT_SCAN       = 4'd2,
		ACT_CNT_RD_HIT = 4'd3,
		ACT_CNT_WR     = 4'd4,
		ACT_INSERT     = 4'd5,
		ACT_CNT_RD_IDX = 4'd6,
		ACT_CNT_RESULT = 4'd7,
		ACT_EMIT       = 4'd8
	} act_t;

	typedef enum logic [2:0] {
		COND_NEXT     = 3'd0,
		COND_GOTO     = 3'd1,
		COND_DISPATCH = 3'd2,
		COND_SKIP     = 3'd3,
		COND_SCAN     = 3'd4,
		COND_OUT_FREE = 3'd5
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// control store
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		unique case (pc)
			U_FETCH:    w = '{ACT_FETCH,      COND_DISPATCH, U_FETCH};
			U_LK_START: w = '{ACT_SCAN_START, COND_SKIP,     U_EMIT};
			U_LK_SCAN:  w = '{ACT_SCAN,       COND_SCAN,     U_EMIT};
			U_HIT_RD:   w = '{ACT_CNT_RD_HIT, COND_NEXT,     U_FETCH};
			U_HIT_WR:   w = '{ACT_CNT_WR,     COND_GOTO,     U_EMIT};
			U_INS:      w = '{ACT_INSERT,     COND_GOTO,     U_EMIT};
			U_RD:       w = '{ACT_CNT_RD_IDX, COND_NEXT,     U_FETCH};
			U_RD_DONE:  w = '{ACT_CNT_RESULT, COND_GOTO,     U_EMIT};
			U_EMIT:     w = '{ACT_EMIT,       COND_OUT_FREE, U_FETCH};
			default:    w = '{ACT_EMIT,       COND_GOTO,     U_FETCH};
		endcase
		return w;
	endfunction

	// entry point of each command's routine
	function automatic upc_t dispatch(cmd_t c);
		upc_t pc;
		unique case (c)
			CMD_LOOKUP:   pc = U_LK_START;
			CMD_INSERT:   pc = U_INS;
			CMD_READ_CNT: pc = U_RD;
			CMD_UNUSED:   pc = U_EMIT;
			default:      pc = U_EMIT;
		endcase
		return pc;
	endfunction

endpackage

>>> hw/rtl/rchd_if.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface rchd_req_if import rchd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [WORD_W-1:0]   key_high;
	logic [WORD_W-1:0]   key_low;
	logic [WORD_W-1:0]   value_in_high;
	logic [WORD_W-1:0]   value_in_low;
	logic [CI_W-1:0]     counter_index;

	modport source (
		output valid, cmd, key_high, key_low, value_in_high, value_in_low, counter_index,
		input  ready
	);
	modport sink (
		input  valid, cmd, key_high, key_low, value_in_high, value_in_low, counter_index,
		output ready
	);
endinterface

interface rchd_rsp_if import rchd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [WORD_W-1:0]   value_out_high;
	logic [WORD_W-1:0]   value_out_low;
	logic [DIST_W-1:0]   hit_distance;
	logic [HIT_W-1:0]    counter_value;

	modport source (
		output valid, hit, value_out_high, value_out_low, hit_distance, counter_value,
		input  ready
	);
	modport sink (
		input  valid, hit, value_out_high, value_out_low, hit_distance, counter_value,
		output ready
	);
endinterface

interface rchd_cfg_if import rchd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ring_cache_with_hit_distance.sv
// fully associative key/value cache, fifo replacement, per-distance hit counters
// lookup: the key scan walks from the newest entry back until a hit or the last filled entry,
// skipped when empty or disabled; a hit then reads and updates its distance's hit counter
// throughput: one request at a time, the next accepted once the response is loaded; the
// key scan (one entry per cycle) sets the worst case per request
// reset: hit counters read as zero at once via per-entry valid bits, ring empty, enable 1, limit 20
`timescale 1ns / 1ps

module ring_cache_with_hit_distance import rchd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	rchd_cfg_if.sink   cfg,
	rchd_req_if.sink   req,
	rchd_rsp_if.source rsp
);

	upc_t   upc_q, upc_d;
	uword_t uw;

	logic               en_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   filled_q;
	logic [CNT_W-1:0]   newest_q;

	// request held for the routine
	logic [KEY_W-1:0] item_key_q;
	logic [VAL_W-1:0] item_val_q;
	logic [CI_W-1:0]  item_ci_q;

	// entry ram
	logic [ENT_W-1:0]  ent_mem [RING_DEPTH];
	logic [ENT_W-1:0]  ent_rd_q;
	logic [SLOT_W-1:0] ent_rd_addr;
	logic              ent_we;

	// hit counter ram with reset-valid bits
	logic [HIT_W-1:0]      cnt_mem [RING_DEPTH];
	logic [HIT_W-1:0]      cnt_rd_q;
	logic                  cnt_vld_rd_q;
	logic [RING_DEPTH-1:0] cvalid_q;
	logic [SLOT_W-1:0]     cnt_rd_addr;
	logic [HIT_W-1:0]      cnt_old;
	logic [HIT_W-1:0]      cnt_new;
	logic                  cnt_we;

	// scan state
	logic [SLOT_W-1:0] scan_slot_q;
	logic [SLOT_W-1:0] cmp_d_q;
	logic [SLOT_W-1:0] hit_d_q;
	logic [SLOT_W-1:0] start_slot;
	logic [SLOT_W-1:0] last_slot;
	logic              scan_hit;
	logic              scan_last;
	logic              lk_skip;

	// insert pointer update
	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  ins_filled;
	logic [CNT_W-1:0]  ins_newest;
	logic [SLOT_W-1:0] ins_slot;

	// result being built, then the output register
	logic              res_hit_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [DIST_W-1:0] res_dist_q;
	logic [HIT_W-1:0]  res_cnt_q;

	logic              out_valid_q;
	logic              out_hit_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [DIST_W-1:0] out_dist_q;
	logic [HIT_W-1:0]  out_cnt_q;

	logic req_fire;
	logic out_free;
	logic ci_in_range;

	assign cfg.ready = 1'b1;
	assign req.ready = (uw.act == ACT_FETCH);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.hit            = out_hit_q;
	assign rsp.value_out_high = out_val_q[VAL_W-1 -: WORD_W];
	assign rsp.value_out_low  = out_val_q[WORD_W-1:0];
	assign rsp.hit_distance   = out_dist_q;
	assign rsp.counter_value  = out_cnt_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		uw = ucode(upc_q);
		unique case (uw.cond)
			COND_NEXT:     upc_d = upc_t'(upc_q + 4'd1);
			COND_GOTO:     upc_d = uw.target;
			COND_DISPATCH: upc_d = req_fire ? dispatch(cmd_t'(req.cmd)) : upc_q;
			COND_SKIP:     upc_d = lk_skip ? uw.target : upc_t'(upc_q + 4'd1);
			COND_SCAN: begin
				if (scan_hit)
					upc_d = upc_t'(upc_q + 4'd1);
				else if (scan_last)
					upc_d = uw.target;
				else
					upc_d = upc_q;
			end
			COND_OUT_FREE: upc_d = out_free ? uw.target : upc_q;
			default:       upc_d = U_FETCH;
		endcase
	end

	// ---------------- datapath logic ----------------
	always_comb begin
		lk_skip    = !en_q || (filled_q == '0) || (newest_q == '0);
		start_slot = SLOT_W'(newest_q - CNT_W'(1));
		last_slot  = SLOT_W'(filled_q - CNT_W'(1));
		scan_hit   = (ent_rd_q[ENT_W-1 -: KEY_W] == item_key_q);
		scan_last  = (CNT_W'(cmp_d_q) == filled_q - CNT_W'(1));

		// walk from newest back to oldest, wrapping at the fill
		ent_rd_addr = (uw.act == ACT_SCAN_START) ? start_slot : scan_slot_q;

		// limit clamp: zero acts as one, above depth acts as depth
		if (limit_q == '0)
			lim = CNT_W'(1);
		else if (32'(limit_q) > RING_DEPTH)
			lim = CNT_W'(RING_DEPTH);
		else
			lim = CNT_W'(limit_q);

		ins_filled = filled_q;
		if ((filled_q < lim) && (newest_q == filled_q)) begin
			ins_filled = filled_q + CNT_W'(1);
			ins_newest = newest_q + CNT_W'(1);
		end else if (newest_q >= lim) begin
			ins_newest = CNT_W'(1);
		end else begin
			ins_newest = newest_q + CNT_W'(1);
		end
		ins_slot = SLOT_W'(ins_newest - CNT_W'(1));
		ent_we   = (uw.act == ACT_INSERT) && en_q;

		cnt_rd_addr = (uw.act == ACT_CNT_RD_HIT) ? hit_d_q : SLOT_W'(item_ci_q);
		cnt_old     = cnt_vld_rd_q ? cnt_rd_q : '0;
		cnt_new     = (cnt_old == HIT_MAX) ? cnt_old : cnt_old + HIT_W'(1);
		cnt_we      = (uw.act == ACT_CNT_WR);
		ci_in_range = (32'(item_ci_q) < RING_DEPTH);
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ins_slot] <= {item_key_q, item_val_q};
		ent_rd_q <= ent_mem[ent_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[hit_d_q] <= cnt_new;
		cnt_rd_q <= cnt_mem[cnt_rd_addr];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b1;
			limit_q      <= LIMIT_RESET;
			filled_q     <= '0;
			newest_q     <= '0;
			cvalid_q     <= '0;
			cnt_vld_rd_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_CACHE_ENABLE)
					en_q <= cfg.data[0];
				else if (cfg.index == REG_ENTRY_LIMIT)
					limit_q <= cfg.data[LIMIT_W-1:0];
			end
			if (ent_we) begin
				filled_q <= ins_filled;
				newest_q <= ins_newest;
			end
			if (cnt_we)
				cvalid_q[hit_d_q] <= 1'b1;
			cnt_vld_rd_q <= cvalid_q[cnt_rd_addr];
			if ((uw.act == ACT_EMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_key_q <= {req.key_high, req.key_low};
			item_val_q <= {req.value_in_high, req.value_in_low};
			item_ci_q  <= req.counter_index;
			res_hit_q  <= 1'b0;
			res_val_q  <= '0;
			res_dist_q <= '0;
			res_cnt_q  <= '0;
		end
		if (uw.act == ACT_SCAN_START) begin
			scan_slot_q <= (start_slot == '0) ? last_slot : start_slot - SLOT_W'(1);
			cmp_d_q     <= '0;
		end
		if (uw.act == ACT_SCAN) begin
			scan_slot_q <= (scan_slot_q == '0) ? last_slot : scan_slot_q - SLOT_W'(1);
			cmp_d_q     <= cmp_d_q + SLOT_W'(1);
			if (scan_hit) begin
				res_hit_q  <= 1'b1;
				res_val_q  <= ent_rd_q[VAL_W-1:0];
				res_dist_q <= DIST_W'(cmp_d_q);
				hit_d_q    <= cmp_d_q;
			end
		end
		if (uw.act == ACT_CNT_RESULT)
			res_cnt_q <= (ci_in_range && cnt_vld_rd_q) ? cnt_rd_q : '0;
		if ((uw.act == ACT_EMIT) && out_free) begin
			out_hit_q  <= res_hit_q;
			out_val_q  <= res_val_q;
			out_dist_q <= res_dist_q;
			out_cnt_q  <= res_cnt_q;
		end
	end

`ifndef SYNTHESIS
	a_newest_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		newest_q <= filled_q)
		else $error("newest slot beyond filled region");

	a_fill_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= RING_DEPTH)
		else $error("fill count beyond ring depth");

	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_LK_SCAN) |-> (CNT_W'(cmp_d_q) < filled_q))
		else $error("scan distance ran past the filled entries");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(upc_q == U_EMIT))
		else $error("response raised outside the emit step");
`endif

endmodule
